FILE: sv/metp_pkg.sv
// Shared types and constants of the Mandelbrot escape-time pixel unit.
// Holds field widths, colour multipliers, register indexes, reset values and item structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package metp_pkg;

   // field widths
   localparam int COORD_W     = 10;
   localparam int ITER_W      = 12;
   localparam int CFG_W       = 32;
   localparam int T_W         = 8;
   localparam int QUEUE_DEPTH = 2;

   // colour and escape constants
   localparam int unsigned COLOUR_MAX       = 255;
   localparam int unsigned K_RED            = 5851;
   localparam int unsigned K_GREEN          = 6353;
   localparam int unsigned K_BLUE           = 7673;
   localparam int unsigned ESCAPE_RADIUS_SQ = 4;

   // view register indexes
   typedef enum logic [2:0] {
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_STEP_X,
      REG_STEP_Y,
      REG_MAX_ITER
   } csr_index_type;

   // view and limit registers
   typedef struct packed {
      logic [CFG_W-1:0]  origin_x;
      logic [CFG_W-1:0]  origin_y;
      logic [CFG_W-1:0]  step_x;
      logic [CFG_W-1:0]  step_y;
      logic [ITER_W-1:0] max_iter;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      origin_x: 32'hD800_0000,
      origin_y: 32'hF000_0000,
      step_x:   32'd978670,
      step_y:   32'd994205,
      max_iter: 12'd128
   };

   // item queued between the front end and the iteration engine
   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic [CFG_W-1:0]   cx;
      logic [CFG_W-1:0]   cy;
   } point_type;

   // finished item handed from the iteration engine to the shading unit
   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic [ITER_W-1:0]  iterations;
   } pixel_done_type;

endpackage

`default_nettype wire

FILE: sv/metp_front.sv
// Front end: takes pixel items, clamps the indices and forms the point c.
// Depends on metp_pkg; feeds metp_queue.
`timescale 1ns / 1ps
`default_nettype none

module metp_front #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  wire  [metp_pkg::COORD_W-1:0]   req_column,
   input  wire  [metp_pkg::COORD_W-1:0]   req_row,
   input  wire  metp_pkg::cfg_type        cfg,
   output logic                           q_push,
   output metp_pkg::point_type            q_item,
   input  wire                            q_full
);

   localparam int CW = metp_pkg::COORD_W;
   localparam int KW = metp_pkg::CFG_W;
   localparam logic [CW-1:0] COL_LAST =
      (MAX_COLUMNS > (1 << CW)) ? {CW{1'b1}} : CW'(MAX_COLUMNS - 1);
   localparam logic [CW-1:0] ROW_LAST =
      (MAX_ROWS > (1 << CW)) ? {CW{1'b1}} : CW'(MAX_ROWS - 1);

   logic          valid_ff, valid_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] cidx_ff, cidx_in;
   logic [CW-1:0] ridx_ff, ridx_in;
   logic          accept;
   logic [CW+KW-1:0] prod_x, prod_y;

   // hold the item until the queue has room
   assign busy   = valid_ff & q_full;
   assign q_push = valid_ff & ~q_full;
   assign accept = start & ~busy;

   // capture and clamp the indices
   always_comb begin
      valid_in = accept | (valid_ff & ~q_push);
      col_in   = col_ff;
      row_in   = row_ff;
      cidx_in  = cidx_ff;
      ridx_in  = ridx_ff;
      if (accept) begin
         col_in  = req_column;
         row_in  = req_row;
         cidx_in = (int'(req_column) < MAX_COLUMNS) ? req_column : COL_LAST;
         ridx_in = (int'(req_row) < MAX_ROWS) ? req_row : ROW_LAST;
      end
   end

   // form c modulo the register width
   always_comb begin
      prod_x        = (CW+KW)'(cidx_ff) * (CW+KW)'(cfg.step_x);
      prod_y        = (CW+KW)'(ridx_ff) * (CW+KW)'(cfg.step_y);
      q_item.column = col_ff;
      q_item.row    = row_ff;
      q_item.cx     = cfg.origin_x + prod_x[KW-1:0];
      q_item.cy     = cfg.origin_y + prod_y[KW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      col_ff  <= col_in;
      row_ff  <= row_in;
      cidx_ff <= cidx_in;
      ridx_ff <= ridx_in;
   end

endmodule

`default_nettype wire

FILE: sv/metp_queue.sv
// Short item queue between the front end and the iteration engine.
// Depends on metp_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module metp_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire  metp_pkg::point_type  push_item,
   output logic                       full,
   input  wire                        pop,
   output metp_pkg::point_type        head,
   output logic                       empty
);

   localparam int DEPTH = metp_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   metp_pkg::point_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign full    = (fill_ff == NW'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: sv/metp_engine.sv
// Iteration engine: runs z = z^2 + c on 64-bit fixed point, one pass of multiply, assemble and update per iteration.
// Depends on metp_pkg; pops metp_queue and hands finished items to metp_shade.
`timescale 1ns / 1ps
`default_nettype none

module metp_engine #(
   parameter int FRAC_BITS = 28
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  [metp_pkg::ITER_W-1:0]        max_iter,
   input  wire  metp_pkg::point_type          q_head,
   input  wire                                q_empty,
   output logic                               q_pop,
   output logic                               done_valid,
   output metp_pkg::pixel_done_type           done_item,
   input  wire                                done_ready
);

   localparam int ZW = 64;
   localparam int HW = ZW / 2;
   localparam int PW = 2 * ZW;
   localparam int CW = metp_pkg::COORD_W;
   localparam int IW = metp_pkg::ITER_W;
   localparam logic [ZW-1:0] ESCAPE_LIMIT = ZW'(metp_pkg::ESCAPE_RADIUS_SQ) << FRAC_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_UPD
   } state_type;

   // signed high half times signed high half
   function automatic logic [ZW-1:0] mul_ss(input logic [HW-1:0] a, input logic [HW-1:0] b);
      logic signed [HW:0]     sa;
      logic signed [HW:0]     sb;
      logic signed [2*HW+1:0] p;
      sa = $signed({a[HW-1], a});
      sb = $signed({b[HW-1], b});
      p  = sa * sb;
      return p[ZW-1:0];
   endfunction

   // signed high half times unsigned low half
   function automatic logic [ZW-1:0] mul_su(input logic [HW-1:0] a, input logic [HW-1:0] b);
      logic signed [HW:0]     sa;
      logic signed [HW:0]     sb;
      logic signed [2*HW+1:0] p;
      sa = $signed({a[HW-1], a});
      sb = $signed({1'b0, b});
      p  = sa * sb;
      return p[ZW-1:0];
   endfunction

   // unsigned low half times unsigned low half
   function automatic logic [ZW-1:0] mul_uu(input logic [HW-1:0] a, input logic [HW-1:0] b);
      logic [ZW-1:0] p;
      p = ZW'(a) * ZW'(b);
      return p;
   endfunction

   state_type     state_ff, state_in;
   logic [ZW-1:0] x_ff, x_in;
   logic [ZW-1:0] y_ff, y_in;
   logic [ZW-1:0] cx_ff, cx_in;
   logic [ZW-1:0] cy_ff, cy_in;
   logic [IW-1:0] count_ff, count_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;

   logic [ZW-1:0] pp_x_hh_ff, pp_x_hl_ff, pp_x_ll_ff;
   logic [ZW-1:0] pp_y_hh_ff, pp_y_hl_ff, pp_y_ll_ff;
   logic [ZW-1:0] pp_xy_hh_ff, pp_xy_hl_ff, pp_xy_lh_ff, pp_xy_ll_ff;
   logic [ZW-1:0] x2_ff, x2_in;
   logic [ZW-1:0] y2_ff, y2_in;
   logic [ZW-1:0] xy2_ff, xy2_in;

   logic [PW-1:0] sq_x, sq_y, prod_xy;
   logic [ZW-1:0] mag_sq;
   logic          escape;

   // assemble the wide products and drop the fraction
   always_comb begin
      sq_x = {pp_x_hh_ff, {ZW{1'b0}}}
           + {{(HW-1){pp_x_hl_ff[ZW-1]}}, pp_x_hl_ff, {(HW+1){1'b0}}}
           + {{ZW{1'b0}}, pp_x_ll_ff};
      sq_y = {pp_y_hh_ff, {ZW{1'b0}}}
           + {{(HW-1){pp_y_hl_ff[ZW-1]}}, pp_y_hl_ff, {(HW+1){1'b0}}}
           + {{ZW{1'b0}}, pp_y_ll_ff};
      prod_xy = {pp_xy_hh_ff, {ZW{1'b0}}}
              + {{HW{pp_xy_hl_ff[ZW-1]}}, pp_xy_hl_ff, {HW{1'b0}}}
              + {{HW{pp_xy_lh_ff[ZW-1]}}, pp_xy_lh_ff, {HW{1'b0}}}
              + {{ZW{1'b0}}, pp_xy_ll_ff};
      x2_in  = sq_x[FRAC_BITS +: ZW];
      y2_in  = sq_y[FRAC_BITS +: ZW];
      xy2_in = prod_xy[FRAC_BITS-1 +: ZW];
   end

   // escape test on the current z
   assign mag_sq = x2_ff + y2_ff;
   assign escape = (mag_sq > ESCAPE_LIMIT) || (count_ff >= max_iter);

   assign done_valid          = (state_ff == ST_UPD) && escape;
   assign done_item.column     = col_ff;
   assign done_item.row        = row_ff;
   assign done_item.iterations = count_ff;
   assign q_pop               = (state_ff == ST_IDLE) && !q_empty;

   // sequence the multiply, assemble and update steps
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      count_in = count_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               x_in     = '0;
               y_in     = '0;
               cx_in    = ZW'($signed(q_head.cx));
               cy_in    = ZW'($signed(q_head.cy));
               count_in = '0;
               col_in   = q_head.column;
               row_in   = q_head.row;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (escape) begin
               if (done_ready) begin
                  state_in = ST_IDLE;
               end
            end else begin
               x_in     = x2_ff - y2_ff + cx_ff;
               y_in     = xy2_ff + cy_ff;
               count_in = count_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      count_ff <= count_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      // partial products of the current z
      pp_x_hh_ff  <= mul_ss(x_ff[ZW-1:HW], x_ff[ZW-1:HW]);
      pp_x_hl_ff  <= mul_su(x_ff[ZW-1:HW], x_ff[HW-1:0]);
      pp_x_ll_ff  <= mul_uu(x_ff[HW-1:0], x_ff[HW-1:0]);
      pp_y_hh_ff  <= mul_ss(y_ff[ZW-1:HW], y_ff[ZW-1:HW]);
      pp_y_hl_ff  <= mul_su(y_ff[ZW-1:HW], y_ff[HW-1:0]);
      pp_y_ll_ff  <= mul_uu(y_ff[HW-1:0], y_ff[HW-1:0]);
      pp_xy_hh_ff <= mul_ss(x_ff[ZW-1:HW], y_ff[ZW-1:HW]);
      pp_xy_hl_ff <= mul_su(x_ff[ZW-1:HW], y_ff[HW-1:0]);
      pp_xy_lh_ff <= mul_su(y_ff[ZW-1:HW], x_ff[HW-1:0]);
      pp_xy_ll_ff <= mul_uu(x_ff[HW-1:0], y_ff[HW-1:0]);
      x2_ff  <= x2_in;
      y2_ff  <= y2_in;
      xy2_ff <= xy2_in;
   end

endmodule

`default_nettype wire

FILE: sv/metp_shade.sv
// Shading unit: scales the count to 0..255 with a bit-serial divider, then maps colours.
// Depends on metp_pkg; drives the result ports of the top level.
`timescale 1ns / 1ps
`default_nettype none

module metp_shade (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [metp_pkg::ITER_W-1:0]       max_iter,
   input  wire                               in_valid,
   input  wire  metp_pkg::pixel_done_type    in_item,
   output logic                              in_ready,
   output logic                              rsp_valid,
   output logic [metp_pkg::COORD_W-1:0]      rsp_out_column,
   output logic [metp_pkg::COORD_W-1:0]      rsp_out_row,
   output logic [metp_pkg::ITER_W-1:0]       rsp_iterations,
   output logic [7:0]                        rsp_red,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_blue
);

   localparam int CW = metp_pkg::COORD_W;
   localparam int IW = metp_pkg::ITER_W;
   localparam int TW = metp_pkg::T_W;
   localparam int NW = IW + TW;
   localparam int SW = $clog2(TW);
   localparam logic [7:0] CMAX     = 8'(metp_pkg::COLOUR_MAX);
   localparam logic [7:0] KM_RED   = 8'(metp_pkg::K_RED % metp_pkg::COLOUR_MAX);
   localparam logic [7:0] KM_GREEN = 8'(metp_pkg::K_GREEN % metp_pkg::COLOUR_MAX);
   localparam logic [7:0] KM_BLUE  = 8'(metp_pkg::K_BLUE % metp_pkg::COLOUR_MAX);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MAP
   } state_type;

   // 255 - (t*k) mod 255, with k already reduced mod 255
   function automatic logic [7:0] shade_byte(input logic [TW-1:0] t, input logic [7:0] kmod);
      logic [15:0] p;
      logic [8:0]  s1;
      logic [8:0]  s2;
      logic [7:0]  m;
      p  = 16'(t) * 16'(kmod);
      s1 = 9'(p[15:8]) + 9'(p[7:0]);
      s2 = 9'(s1[8]) + 9'(s1[7:0]);
      m  = (s2 == 9'(CMAX)) ? 8'd0 : s2[7:0];
      return CMAX - m;
   endfunction

   state_type     state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] dsh_ff, dsh_in;
   logic [TW-1:0] quo_ff, quo_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic          valid_ff, valid_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [CW-1:0] out_row_ff, out_row_in;
   logic [IW-1:0] out_iter_ff, out_iter_in;
   logic [7:0]    red_ff, red_in;
   logic [7:0]    green_ff, green_in;
   logic [7:0]    blue_ff, blue_in;
   logic          fits;
   logic [TW-1:0] t_val;

   assign in_ready = (state_ff == ST_IDLE);
   assign fits     = (rem_ff >= dsh_ff);
   assign t_val    = (max_iter == '0) ? '0 : quo_ff;

   // load, divide one quotient bit a cycle, then map
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      rem_in      = rem_ff;
      dsh_in      = dsh_ff;
      quo_in      = quo_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      iter_in     = iter_ff;
      valid_in    = 1'b0;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_iter_in = out_iter_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      blue_in     = blue_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               rem_in   = NW'(in_item.iterations) * NW'(metp_pkg::COLOUR_MAX);
               dsh_in   = NW'(max_iter) << (TW - 1);
               quo_in   = '0;
               step_in  = SW'(TW - 1);
               col_in   = in_item.column;
               row_in   = in_item.row;
               iter_in  = in_item.iterations;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (fits) begin
               rem_in = rem_ff - dsh_ff;
            end
            quo_in = {quo_ff[TW-2:0], fits};
            dsh_in = dsh_ff >> 1;
            if (step_ff == '0) begin
               state_in = ST_MAP;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_MAP: begin
            out_col_in  = col_ff;
            out_row_in  = row_ff;
            out_iter_in = iter_ff;
            red_in      = shade_byte(t_val, KM_RED);
            green_in    = shade_byte(t_val, KM_GREEN);
            blue_in     = shade_byte(t_val, KM_BLUE);
            valid_in    = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      iter_ff     <= iter_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_iter_ff <= out_iter_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_column = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_iterations = out_iter_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;

endmodule

`default_nettype wire

FILE: sv/mandelbrot_escape_time_pixel_unit.sv
// Top level of the Mandelbrot escape-time pixel unit: view registers, front end,
// item queue, iteration engine and shading unit. Depends on metp_pkg and all metp_ modules.
//
// A pixel item (req_column, req_row) is taken at a rising edge where start is high and busy
// is low; busy is high only while the front register holds an item and the two-entry queue
// is full. Each item gives exactly one result, shown for a single cycle with rsp_valid high;
// the receiver cannot hold it off, so it must take every strobe. The iteration engine runs
// z = z^2 + c passes of partial products, product assembly, and escape test and update,
// and holds a finished item until the shading unit (eight-step divider plus colour map)
// takes it; the shading unit runs beside the engine, which starts on its next item while
// the last one is being shaded. View registers are written through csr_write_en, csr_index
// and csr_wdata and are meant to change only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_pixel_unit #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024,
   parameter int FRAC_BITS   = 28
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  wire  [metp_pkg::COORD_W-1:0]    req_column,
   input  wire  [metp_pkg::COORD_W-1:0]    req_row,
   output logic                            rsp_valid,
   output logic [metp_pkg::COORD_W-1:0]    rsp_out_column,
   output logic [metp_pkg::COORD_W-1:0]    rsp_out_row,
   output logic [metp_pkg::ITER_W-1:0]     rsp_iterations,
   output logic [7:0]                      rsp_red,
   output logic [7:0]                      rsp_green,
   output logic [7:0]                      rsp_blue,
   input  wire                             csr_write_en,
   input  wire  [2:0]                      csr_index,
   input  wire  [metp_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int SHADE_LAT = metp_pkg::T_W + 2;

   metp_pkg::cfg_type        cfg_ff, cfg_in;
   logic                     q_push, q_full, q_pop, q_empty;
   metp_pkg::point_type      q_item, q_head;
   logic                     done_valid, done_ready;
   metp_pkg::pixel_done_type done_item;

   // write the view registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            metp_pkg::REG_ORIGIN_X: cfg_in.origin_x = csr_wdata;
            metp_pkg::REG_ORIGIN_Y: cfg_in.origin_y = csr_wdata;
            metp_pkg::REG_STEP_X:   cfg_in.step_x   = csr_wdata;
            metp_pkg::REG_STEP_Y:   cfg_in.step_y   = csr_wdata;
            metp_pkg::REG_MAX_ITER: cfg_in.max_iter = csr_wdata[metp_pkg::ITER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= metp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   metp_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_column (req_column),
      .req_row    (req_row),
      .cfg        (cfg_ff),
      .q_push     (q_push),
      .q_item     (q_item),
      .q_full     (q_full)
   );

   metp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   metp_engine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .max_iter   (cfg_ff.max_iter),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .done_valid (done_valid),
      .done_item  (done_item),
      .done_ready (done_ready)
   );

   metp_shade u_shade (
      .clock          (clock),
      .reset          (reset),
      .max_iter       (cfg_ff.max_iter),
      .in_valid       (done_valid),
      .in_item        (done_item),
      .in_ready       (done_ready),
      .rsp_valid      (rsp_valid),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_iterations (rsp_iterations),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // a result strobe lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // busy can only come up right after an item was offered
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a preceding item");

   // every item handed to the shading unit comes out once its divide and colour map are done
   a_shade_latency: assert property (@(posedge clock) disable iff (reset)
      (done_valid && done_ready) |-> ##SHADE_LAT rsp_valid)
      else $error("shading unit missed its result slot");

endmodule

`default_nettype wire

FILE: sim/mandelbrot_escape_time_pixel_unit_tb.sv
// Self-checking testbench of the Mandelbrot escape-time pixel unit: directed pixels, then
// random pixels over several views and iteration limits, checked against a built-in predictor.
// Depends on metp_pkg and mandelbrot_escape_time_pixel_unit.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_unit_tb;

   localparam int COORD_W       = metp_pkg::COORD_W;
   localparam int ITER_W        = metp_pkg::ITER_W;
   localparam int CFG_W         = metp_pkg::CFG_W;
   localparam int PIXEL_COLUMNS = 1024;
   localparam int PIXEL_ROWS    = 1024;
   localparam int FRACTION_BITS = 28;
   localparam int SETTLE_CYCLES = 64;
   localparam int REPORT_LIMIT  = 10;

   // pixel inside the main cardioid of the default view
   localparam int CARDIOID_COLUMN = 548;
   localparam int CARDIOID_ROW    = 270;

   typedef struct {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic [ITER_W-1:0]  iterations;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } shaded_pixel_type;

   // Predicts the shaded pixel of each accepted item and checks results in order.
   class escape_scoreboard_type;
      metp_pkg::cfg_type view;
      shaded_pixel_type  awaited_pixels[$];
      int unsigned       mismatches;

      function new();
         view       = metp_pkg::CFG_RESET;
         mismatches = 0;
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%s", what);
      endfunction

      // signed product divided by 2^shift, rounded toward minus infinity, low 64 bits
      function logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                  logic signed [63:0] b,
                                                  int unsigned shift);
         logic signed [127:0] wide_a;
         logic signed [127:0] wide_b;
         logic signed [127:0] wide;
         wide_a = a;
         wide_b = b;
         wide   = wide_a * wide_b;
         wide   = wide >>> shift;
         return wide[63:0];
      endfunction

      function logic [7:0] colour_byte(int unsigned level, int unsigned k);
         return 8'(metp_pkg::COLOUR_MAX - (level * k) % metp_pkg::COLOUR_MAX);
      endfunction

      function shaded_pixel_type predict(logic [COORD_W-1:0] column,
                                         logic [COORD_W-1:0] row);
         shaded_pixel_type   px;
         logic [CFG_W-1:0]   col_idx;
         logic [CFG_W-1:0]   row_idx;
         logic [CFG_W-1:0]   re32;
         logic [CFG_W-1:0]   im32;
         logic signed [63:0] cx;
         logic signed [63:0] cy;
         logic signed [63:0] zx;
         logic signed [63:0] zy;
         logic signed [63:0] zx2;
         logic signed [63:0] zy2;
         logic signed [63:0] next_x;
         logic [63:0]        radius_sq;
         logic [63:0]        limit;
         int unsigned        count;
         int unsigned        level;

         // clamp the index, then place the point modulo 2^32
         col_idx = (int'(column) < PIXEL_COLUMNS) ? CFG_W'(column) : CFG_W'(PIXEL_COLUMNS - 1);
         row_idx = (int'(row) < PIXEL_ROWS) ? CFG_W'(row) : CFG_W'(PIXEL_ROWS - 1);
         re32 = view.origin_x + col_idx * view.step_x;
         im32 = view.origin_y + row_idx * view.step_y;
         cx   = {{32{re32[31]}}, re32};
         cy   = {{32{im32[31]}}, im32};

         // iterate z = z^2 + c until escape or the limit
         limit = 64'(metp_pkg::ESCAPE_RADIUS_SQ) << FRACTION_BITS;
         zx    = '0;
         zy    = '0;
         count = 0;
         forever begin
            zx2       = scaled_product(zx, zx, FRACTION_BITS);
            zy2       = scaled_product(zy, zy, FRACTION_BITS);
            radius_sq = zx2 + zy2;
            if (radius_sq > limit || count >= view.max_iter)
               break;
            next_x = zx2 - zy2 + cx;
            zy     = scaled_product(zx, zy, FRACTION_BITS - 1) + cy;
            zx     = next_x;
            count++;
         end

         level = 0;
         if (view.max_iter != 0)
            level = (metp_pkg::COLOUR_MAX * count) / view.max_iter;

         px.column     = column;
         px.row        = row;
         px.iterations = ITER_W'(count);
         px.red        = colour_byte(level, metp_pkg::K_RED);
         px.green      = colour_byte(level, metp_pkg::K_GREEN);
         px.blue       = colour_byte(level, metp_pkg::K_BLUE);
         return px;
      endfunction

      function void note_pixel(logic [COORD_W-1:0] column, logic [COORD_W-1:0] row);
         awaited_pixels.push_back(predict(column, row));
      endfunction

      function void check_pixel(logic [COORD_W-1:0] column, logic [COORD_W-1:0] row,
                                logic [ITER_W-1:0] iterations, logic [7:0] red,
                                logic [7:0] green, logic [7:0] blue);
         shaded_pixel_type want;
         if (awaited_pixels.size() == 0) begin
            flag($sformatf("unexpected result at %0t: pixel (%0d,%0d) it=%0d",
                           $time, column, row, iterations));
            return;
         end
         want = awaited_pixels.pop_front();
         if (column !== want.column || row !== want.row || iterations !== want.iterations ||
             red !== want.red || green !== want.green || blue !== want.blue)
            flag($sformatf({"mismatch at %0t: expected (%0d,%0d) it=%0d rgb=%h/%h/%h,",
                            " got (%0d,%0d) it=%0d rgb=%h/%h/%h"}, $time,
                           want.column, want.row, want.iterations, want.red, want.green,
                           want.blue, column, row, iterations, red, green, blue));
      endfunction
   endclass

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               start        = 1'b0;
   logic [COORD_W-1:0] req_column   = '0;
   logic [COORD_W-1:0] req_row      = '0;
   logic               csr_write_en = 1'b0;
   logic [2:0]         csr_index    = '0;
   logic [CFG_W-1:0]   csr_wdata    = '0;
   wire                busy;
   wire                rsp_valid;
   wire [COORD_W-1:0]  rsp_out_column;
   wire [COORD_W-1:0]  rsp_out_row;
   wire [ITER_W-1:0]   rsp_iterations;
   wire [7:0]          rsp_red;
   wire [7:0]          rsp_green;
   wire [7:0]          rsp_blue;

   escape_scoreboard_type sb = new();

   mandelbrot_escape_time_pixel_unit #(
      .MAX_COLUMNS(PIXEL_COLUMNS),
      .MAX_ROWS   (PIXEL_ROWS),
      .FRAC_BITS  (FRACTION_BITS)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_column    (req_column),
      .req_row       (req_row),
      .rsp_valid     (rsp_valid),
      .rsp_out_column(rsp_out_column),
      .rsp_out_row   (rsp_out_row),
      .rsp_iterations(rsp_iterations),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // note every item the block takes
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_pixel(req_column, req_row);
   end

   // check every result strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_pixel(rsp_out_column, rsp_out_row, rsp_iterations, rsp_red, rsp_green,
                        rsp_blue);
   end

   task automatic write_reg(logic [2:0] index, logic [CFG_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   // load a whole view while the block is idle
   task automatic program_view(metp_pkg::cfg_type v);
      write_reg(metp_pkg::REG_ORIGIN_X, v.origin_x);
      write_reg(metp_pkg::REG_ORIGIN_Y, v.origin_y);
      write_reg(metp_pkg::REG_STEP_X, v.step_x);
      write_reg(metp_pkg::REG_STEP_Y, v.step_y);
      write_reg(metp_pkg::REG_MAX_ITER, {20'($urandom), v.max_iter});
      // an unused index must leave the view alone
      write_reg(3'($urandom_range(7, metp_pkg::REG_MAX_ITER + 1)), $urandom);
      csr_write_en <= 1'b0;
      sb.view = v;
   endtask

   // hold start until the block takes the item, idling first at random
   task automatic send_pixel(int column, int row, int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_column <= COORD_W'(column);
      req_row    <= COORD_W'(row);
      do @(posedge clock); while (busy);
   endtask

   // drop start and wait for every awaited result
   task automatic close_items();
      start <= 1'b0;
      // let the last item reach the scoreboard first
      @(posedge clock);
      while (sb.awaited_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random(int unsigned items, int unsigned idle_pct);
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      repeat (items) begin
         column = COORD_W'($urandom);
         row    = COORD_W'($urandom);
         // pull some items onto the edges of the frame
         if ($urandom_range(7) == 0)
            column = $urandom_range(1) ? '1 : '0;
         if ($urandom_range(7) == 0)
            row = $urandom_range(1) ? '1 : '0;
         send_pixel(column, row, idle_pct);
      end
      close_items();
   endtask

   function automatic metp_pkg::cfg_type make_view(int ox, int oy, int sx, int sy,
                                                   int unsigned limit);
      metp_pkg::cfg_type v;
      v.origin_x = CFG_W'(ox);
      v.origin_y = CFG_W'(oy);
      v.step_x   = CFG_W'(sx);
      v.step_y   = CFG_W'(sy);
      v.max_iter = ITER_W'(limit);
      return v;
   endfunction

   // a view over the set, or anywhere in the register range
   function automatic metp_pkg::cfg_type random_view(bit anywhere, int unsigned limit);
      metp_pkg::cfg_type v;
      if (anywhere) begin
         v.origin_x = $urandom;
         v.origin_y = $urandom;
         v.step_x   = $urandom;
         v.step_y   = $urandom;
      end else begin
         v.origin_x = CFG_W'(int'($urandom_range(805306368)) - 671088640);
         v.origin_y = CFG_W'(int'($urandom_range(536870912)) - 402653184);
         v.step_x   = CFG_W'($urandom_range(1048575));
         v.step_y   = CFG_W'($urandom_range(1048575));
         if ($urandom_range(1))
            v.step_x = -v.step_x;
         if ($urandom_range(1))
            v.step_y = -v.step_y;
      end
      v.max_iter = ITER_W'(limit);
      return v;
   endfunction

   initial begin
      #50_000_000;
      $display("mandelbrot_escape_time_pixel_unit_tb: errors");
      $finish;
   end

   initial begin
      metp_pkg::cfg_type v;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset view: frame corners, alternating bits, a point inside
      send_pixel(0, 0, 0);
      send_pixel(1023, 1023, 0);
      send_pixel(0, 1023, 0);
      send_pixel(1023, 0, 0);
      send_pixel(10'h2AA, 10'h155, 0);
      send_pixel(10'h155, 10'h2AA, 0);
      send_pixel(512, 512, 0);
      send_pixel(CARDIOID_COLUMN, CARDIOID_ROW, 0);
      close_items();

      // zero iteration limit: all channels white
      v = metp_pkg::CFG_RESET;
      v.max_iter = 0;
      program_view(v);
      send_pixel(CARDIOID_COLUMN, CARDIOID_ROW, 0);
      send_pixel(0, 0, 0);
      close_items();

      // single iteration
      v.max_iter = 1;
      program_view(v);
      send_pixel(CARDIOID_COLUMN, CARDIOID_ROW, 0);
      send_pixel(1023, 1023, 0);
      close_items();

      // extreme registers: points far out, wrapping coordinates
      program_view(make_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             4095));
      send_pixel(0, 0, 0);
      send_pixel(1, 1, 0);
      send_pixel(1023, 1023, 0);
      close_items();

      // c = 0 at the largest limit
      program_view(make_view(0, 0, 0, 0, 4095));
      send_pixel(0, 0, 0);
      send_pixel(1023, 1023, 0);
      close_items();

      // random pixels, default view
      program_view(metp_pkg::CFG_RESET);
      run_random(240, 0);
      v = metp_pkg::CFG_RESET;
      v.max_iter = 255;
      program_view(v);
      run_random(240, 69);

      // close-up near the boundary
      program_view(make_view(-214748365, 13421773, 26214, 26214, 64));
      run_random(240, 14);

      // random views over the set
      repeat (3) begin
         program_view(random_view(1'b0, $urandom_range(300, 2)));
         run_random(80, 0);
      end

      // random registers over the whole range
      repeat (3) begin
         program_view(random_view(1'b1, $urandom_range(255, 1)));
         run_random(80, 69);
      end

      // short limits on the default view
      v = metp_pkg::CFG_RESET;
      v.max_iter = 16;
      program_view(v);
      run_random(240, 14);
      v.max_iter = 0;
      program_view(v);
      run_random(60, 0);
      v.max_iter = 1;
      program_view(v);
      run_random(60, 69);
      v.max_iter = 2;
      program_view(v);
      run_random(120, 0);

      // largest limit, tight close-up: few items since points inside are slow
      program_view(make_view(-204010946, 21474836, 10486, 10486, 4095));
      run_random(20, 14);

      // catch any stray result
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.awaited_pixels.size() != 0)
         sb.flag($sformatf("%0d results never arrived", sb.awaited_pixels.size()));

      if (sb.mismatches == 0)
         $display("mandelbrot_escape_time_pixel_unit_tb: clean");
      else
         $display("mandelbrot_escape_time_pixel_unit_tb: errors");
      $finish;
   end

endmodule
